### rtl/lvc_pkg.sv
// shared types, constants and the tanh table of the lateral velocity controller
package lvc_pkg;

  // word formats
  localparam int unsigned WORD_W     = 24;
  localparam int unsigned ARG_W      = WORD_W + 1;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned GAIN_BITS  = 16;
  localparam int unsigned LIMIT_W    = 23;
  localparam int unsigned TANH_OUT_W = FRAC_BITS + 2;

  // tanh table geometry
  localparam int unsigned TANH_ENTRIES = 256;
  localparam int unsigned TANH_W       = FRAC_BITS + 1;
  localparam int unsigned TANH_IDX_W   = $clog2(TANH_ENTRIES);
  localparam int unsigned TAB_ADDR_W   = $clog2(TANH_ENTRIES + 1);
  localparam int unsigned SCALED_W     = FRAC_BITS + 2 + TANH_IDX_W;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ERROR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MOTION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_OBSERVER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT     = 3'd4;

  // configuration reset values
  localparam logic signed [WORD_W-1:0] SETPOINT_RST      = 24'sd32768;
  localparam logic [GAIN_BITS-1:0]     GAIN_ERROR_RST    = 16'd5243;
  localparam logic [GAIN_BITS-1:0]     GAIN_MOTION_RST   = 16'd13107;
  localparam logic [GAIN_BITS-1:0]     GAIN_OBSERVER_RST = 16'd6554;
  localparam logic [LIMIT_W-1:0]       OUT_LIMIT_RST     = 23'd45875;

  // configuration register set
  typedef struct packed {
    logic signed [WORD_W-1:0] setpoint;
    logic [GAIN_BITS-1:0]     gain_error;
    logic [GAIN_BITS-1:0]     gain_motion;
    logic [GAIN_BITS-1:0]     gain_observer;
    logic [LIMIT_W-1:0]       out_limit;
  } cfg_regs_t;

  typedef logic [TANH_W-1:0] tanh_tab_t [0:TANH_ENTRIES];

  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

  // q62 fixed-point product, elaboration only
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // restoring long division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] qt;
    logic [63:0] rm;
    qt = '0;
    rm = '0;
    for (int i = 63; i >= 0; i--) begin
      rm = {rm[62:0], n[i]};
      if (rm >= d) begin
        rm = rm - d;
        qt[i] = 1'b1;
      end
    end
    return qt;
  endfunction

  // tanh(4i/entries) scaled by 2^frac, via exp(-2x) from a taylor series
  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t   tab;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    t = ((ONE_Q62 / TANH_ENTRIES) << 3) + (((ONE_Q62 % TANH_ENTRIES) << 3) / TANH_ENTRIES);
    term = ONE_Q62;
    r = ONE_Q62;
    e = ONE_Q62;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64(mul_q62(term, t), 64'(k));
      if (k % 2 == 1) r = r - term;
      else r = r + term;
    end
    for (int i = 0; i <= TANH_ENTRIES; i++) begin
      num = (ONE_Q62 - e) >> 30;
      den = (ONE_Q62 + e) >> 30;
      q = udiv64(num << (FRAC_BITS + 1), den);
      tab[i] = TANH_W'((q + 64'd1) >> 1);
      e = mul_q62(e, r);
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

  // clip a sum one bit wider than a word to the signed word range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ARG_W-1:0] v);
    logic signed [WORD_W-1:0] res;
    if (v[ARG_W-1] != v[ARG_W-2]) begin
      res = v[ARG_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      res = v[WORD_W-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/lvc_tanh.sv
// table-driven tanh with linear interpolation, odd symmetry and saturation
module lvc_tanh
  import lvc_pkg::*;
(
  input  logic signed [ARG_W-1:0]      arg,
  output logic signed [TANH_OUT_W-1:0] y
);

  logic                       neg;
  logic [ARG_W-1:0]           mag;
  logic                       big;
  logic [SCALED_W-1:0]        scaled;
  logic [TANH_IDX_W-1:0]      idx;
  logic [FRAC_BITS+1:0]       frac;
  logic [TAB_ADDR_W-1:0]      addr_a;
  logic [TAB_ADDR_W-1:0]      addr_b;
  logic [TANH_W-1:0]          tab_a;
  logic [TANH_W-1:0]          tab_b;
  logic [TANH_W-1:0]          step;
  logic [TANH_W+FRAC_BITS+1:0] prod;
  logic [TANH_W-1:0]          interp;
  logic [TANH_W-1:0]          mag_y;
  logic signed [TANH_OUT_W-1:0] pos_y;

  // magnitude and range check against 4.0
  assign neg = arg[ARG_W-1];
  assign mag = neg ? ARG_W'(-arg) : ARG_W'(arg);
  assign big = (mag >= ARG_W'(4 << FRAC_BITS));

  // segment index and fraction
  assign scaled = SCALED_W'(mag[FRAC_BITS+1:0]) * SCALED_W'(TANH_ENTRIES);
  assign idx    = scaled[SCALED_W-1:FRAC_BITS+2];
  assign frac   = scaled[FRAC_BITS+1:0];
  assign addr_a = TAB_ADDR_W'(idx);
  assign addr_b = addr_a + TAB_ADDR_W'(1);

  // interpolate between neighboring entries, table rises monotonically
  assign tab_a  = TANH_TAB[addr_a];
  assign tab_b  = TANH_TAB[addr_b];
  assign step   = tab_b - tab_a;
  assign prod   = (TANH_W+FRAC_BITS+2)'(step) * (TANH_W+FRAC_BITS+2)'(frac);
  assign interp = tab_a + TANH_W'(prod >> (FRAC_BITS + 2));
  assign mag_y  = big ? TANH_W'(1 << FRAC_BITS) : interp;

  // restore sign
  assign pos_y = $signed({1'b0, mag_y});
  assign y     = neg ? -pos_y : pos_y;

endmodule

### rtl/lvc_drive.sv
// drive command: gain products, rounding and symmetric clamp
module lvc_drive
  import lvc_pkg::*;
(
  input  cfg_regs_t                cfg,
  input  logic signed [WORD_W-1:0] position,
  input  logic signed [WORD_W-1:0] prev_position,
  input  logic signed [WORD_W-1:0] filtered_term,
  output logic signed [WORD_W-1:0] drive,
  output logic                     clamped
);

  localparam int unsigned PROD_W = ARG_W + GAIN_BITS + 1;
  localparam int unsigned ACC_W  = PROD_W + 2;
  localparam int unsigned RAW_W  = ACC_W - GAIN_BITS;

  logic signed [ARG_W-1:0]  err;
  logic signed [ARG_W-1:0]  motion;
  logic signed [ARG_W-1:0]  filt_ext;
  logic signed [PROD_W-1:0] p_err;
  logic signed [PROD_W-1:0] p_mot;
  logic signed [PROD_W-1:0] p_obs;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [RAW_W-1:0]  raw;
  logic signed [RAW_W-1:0]  lim;

  // error terms
  assign err      = ARG_W'(cfg.setpoint) - ARG_W'(position);
  assign motion   = ARG_W'(position) - ARG_W'(prev_position);
  assign filt_ext = ARG_W'(filtered_term);

  // gain products, gains are unsigned
  assign p_err = err * $signed({1'b0, cfg.gain_error});
  assign p_mot = motion * $signed({1'b0, cfg.gain_motion});
  assign p_obs = filt_ext * $signed({1'b0, cfg.gain_observer});

  // exact sum, round half up to word fraction
  assign acc     = ACC_W'(p_err) - ACC_W'(p_mot) - ACC_W'(p_obs);
  assign rounded = acc + ACC_W'(1 << (GAIN_BITS - 1));
  assign raw     = rounded[ACC_W-1:GAIN_BITS];

  // symmetric clamp
  assign lim = $signed({{(RAW_W-LIMIT_W){1'b0}}, cfg.out_limit});
  always_comb begin
    if (raw > lim) begin
      drive   = WORD_W'(lim);
      clamped = 1'b1;
    end else if (raw < -lim) begin
      drive   = WORD_W'(-lim);
      clamped = 1'b1;
    end else begin
      drive   = WORD_W'(raw);
      clamped = 1'b0;
    end
  end

endmodule

### rtl/lateral_velocity_controller_unit.sv
// lateral velocity controller: input register, drive and observer logic, result register
// path: an accepted position is held in the input register and moves on to the result
//   register, which raises out_valid, once that register is free or draining
// throughput: one position per cycle if not stalled; the single compute stage between
//   both registers updates all observer state as its item moves to the result register
// while a result waits, one more input is taken into the input register if it is empty
// reset (synchronous, rst high): configuration to defaults, observer state to zero, both
//   registers empty
module lateral_velocity_controller_unit
  import lvc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [WORD_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [WORD_W-1:0] position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] drive,
  output logic                     clamped
);

  cfg_regs_t cfg;

  logic                     in_full;
  logic signed [WORD_W-1:0] pos_q;
  logic                     advance;

  logic signed [WORD_W-1:0] prev_position;
  logic signed [WORD_W-1:0] observer_estimate;
  logic signed [WORD_W-1:0] observer_diff;
  logic signed [WORD_W-1:0] filtered_term;

  logic signed [WORD_W-1:0]     drive_next;
  logic                         clamped_next;
  logic signed [ARG_W-1:0]      est_err;
  logic signed [ARG_W-1:0]      filt_err;
  logic signed [TANH_OUT_W-1:0] tanh_est;
  logic signed [TANH_OUT_W-1:0] tanh_filt;
  logic signed [WORD_W-1:0]     estimate_next;
  logic signed [WORD_W-1:0]     diff_next;
  logic signed [WORD_W-1:0]     filtered_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint      <= SETPOINT_RST;
      cfg.gain_error    <= GAIN_ERROR_RST;
      cfg.gain_motion   <= GAIN_MOTION_RST;
      cfg.gain_observer <= GAIN_OBSERVER_RST;
      cfg.out_limit     <= OUT_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SETPOINT:      cfg.setpoint      <= cfg_data;
        REG_GAIN_ERROR:    cfg.gain_error    <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_MOTION:   cfg.gain_motion   <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_OBSERVER: cfg.gain_observer <= cfg_data[GAIN_BITS-1:0];
        REG_OUT_LIMIT:     cfg.out_limit     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: item moves on when the result register is free or draining
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pos_q <= position;
    end
  end

  // drive command from current state
  lvc_drive u_drive (
    .cfg           (cfg),
    .position      (pos_q),
    .prev_position (prev_position),
    .filtered_term (filtered_term),
    .drive         (drive_next),
    .clamped       (clamped_next)
  );

  // observer update
  assign est_err  = ARG_W'(prev_position) - ARG_W'(observer_estimate);
  assign filt_err = ARG_W'(observer_diff) - ARG_W'(filtered_term);

  lvc_tanh u_tanh_est (
    .arg (est_err),
    .y   (tanh_est)
  );

  lvc_tanh u_tanh_filt (
    .arg (filt_err),
    .y   (tanh_filt)
  );

  assign estimate_next = sat_word(ARG_W'(observer_estimate) + ARG_W'(tanh_est));
  assign diff_next     = sat_word(est_err);
  assign filtered_next = sat_word(ARG_W'(filtered_term) + ARG_W'(tanh_filt));

  // observer state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_position     <= '0;
      observer_estimate <= '0;
      observer_diff     <= '0;
      filtered_term     <= '0;
    end else if (advance) begin
      prev_position     <= pos_q;
      observer_estimate <= estimate_next;
      observer_diff     <= diff_next;
      filtered_term     <= filtered_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive   <= drive_next;
      clamped <= clamped_next;
    end
  end

endmodule
